// File: src/svpm_pkg.sv
// Shared constants, types and the sine table for the stereo VCA pan mixer.
`timescale 1ns / 1ps

package svpm_pkg;

  // Channel and field geometry
  localparam int NUM_VCAS   = 4;
  localparam int VCA_W      = 2;
  localparam int SAMPLE_W   = 24;
  localparam int CV_W       = 16;
  localparam int TGT_W      = 14;
  localparam int OUT_W      = 26;
  localparam int MIX_W      = 28;
  localparam int IN_DATA_W  = 2 * SAMPLE_W + 2 * CV_W;
  localparam int OUT_FLD_W  = 2 * OUT_W + 2 * MIX_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;

  // Smoothing ramp (length is a power of two)
  localparam int RAMP_LENGTH = 128;
  localparam int RAMP_SHIFT  = $clog2(RAMP_LENGTH);
  localparam int RAMP_W      = (RAMP_SHIFT > 0) ? RAMP_SHIFT : 1;

  // Internal arithmetic widths
  localparam int SMOOTH_W    = 32;
  localparam int DIFF_W      = 34;
  localparam int GAIN_W      = 18;
  localparam int TURN_BITS   = 27;
  localparam int TAB_W       = 16;
  localparam int GC_W        = 34;
  localparam int MA_W        = 25;
  localparam int MB_W        = 35;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int SCALE_SHIFT = 31;
  localparam longint GAIN_MAX_Q24 = 64'sd3 << 24;

  // Sine table over one full turn, power-of-two entries
  localparam int SINE_TABLE_ENTRIES = 256;
  localparam int TBL_W = $clog2(SINE_TABLE_ENTRIES);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GAIN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PAN_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PAN_3  = 3'd7;

  // Operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_GC_L,
    MUL_GC_R,
    MUL_OUT_L,
    MUL_OUT_R
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     step;
    logic     smooth;
    logic     ctrl;
    logic     tab_rd;
    mul_sel_t mul_sel;
    logic     scale;
    logic     load;
  } svpm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic vca_ok;
    logic out_busy;
  } svpm_status_t;

  // Quarter-wave polynomial coefficients, Q30
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint POLY_Q30 [5] = '{
    64'sd1686629713, -64'sd693598669, 64'sd85569306, -64'sd5026984, 64'sd172270
  };

  typedef logic signed [TAB_W-1:0] sine_table_t [SINE_TABLE_ENTRIES];

  // Fold each entry into the first quadrant and evaluate the odd polynomial
  function automatic sine_table_t build_sine_table();
    sine_table_t tab;
    longint q;
    longint r;
    longint u;
    longint u2;
    longint acc;
    longint s;
    longint v;
    int     k;
    int     i;
    for (k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      q = (64'sd4 * longint'(k)) / SINE_TABLE_ENTRIES;
      r = 64'sd4 * longint'(k) - q * SINE_TABLE_ENTRIES;
      u = (r * ONE_Q30) / SINE_TABLE_ENTRIES;
      if (q[0]) begin
        u = ONE_Q30 - u;
      end
      u2 = (u * u) / ONE_Q30;
      acc = POLY_Q30[4];
      for (i = 3; i >= 0; i--) begin
        acc = POLY_Q30[i] + (acc * u2) / ONE_Q30;
      end
      s = (acc * u) / ONE_Q30;
      if (s < 0) begin
        s = 0;
      end
      v = (s + 64'sd16384) / 64'sd32768;
      if (v > 32767) begin
        v = 32767;
      end
      tab[k] = (q >= 2) ? TAB_W'(-v) : TAB_W'(v);
    end
    return tab;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// File: src/svpm_ctrl.sv
// Sequencing state machine of the stereo VCA pan mixer.
`timescale 1ns / 1ps

module svpm_ctrl
  import svpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  svpm_status_t status,
  output svpm_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_SMOOTH,
    S_CTRL,
    S_TABLE,
    S_MUL_GL,
    S_MUL_GR,
    S_MUL_L,
    S_MUL_R,
    S_SCALE,
    S_MIX
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = status.vca_ok ? S_STEP : S_MIX;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_nxt  = S_CTRL;
      end
      S_CTRL: begin
        cmd.ctrl  = 1'b1;
        state_nxt = S_TABLE;
      end
      S_TABLE: begin
        cmd.tab_rd = 1'b1;
        state_nxt  = S_MUL_GL;
      end
      S_MUL_GL: begin
        cmd.mul_sel = MUL_GC_L;
        state_nxt   = S_MUL_GR;
      end
      S_MUL_GR: begin
        cmd.mul_sel = MUL_GC_R;
        state_nxt   = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_sel = MUL_OUT_L;
        state_nxt   = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_sel = MUL_OUT_R;
        state_nxt   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        // Hold until the output register is free
        if (!status.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/svpm_datapath.sv
// Datapath of the stereo VCA pan mixer: VCA state, shared multiplier, mix and output register.
`timescale 1ns / 1ps

module svpm_datapath
  import svpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [VCA_W-1:0]      in_tuser,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TGT_W-1:0]      cfg_data,
  input  svpm_cmd_t             cmd,
  output svpm_status_t          status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [VCA_W-1:0]      out_tuser
);

  // Configuration targets
  logic        [TGT_W-1:0]    tgt_gain_r [NUM_VCAS];
  logic signed [TGT_W-1:0]    tgt_pan_r  [NUM_VCAS];

  // Per-VCA smoothing state
  logic signed [SMOOTH_W-1:0] smooth_gain_r [NUM_VCAS];
  logic signed [SMOOTH_W-1:0] smooth_pan_r  [NUM_VCAS];
  logic signed [SMOOTH_W-1:0] gain_step_r   [NUM_VCAS];
  logic signed [SMOOTH_W-1:0] pan_step_r    [NUM_VCAS];
  logic        [RAMP_W-1:0]   ramp_pos_r    [NUM_VCAS];

  // Captured item
  logic        [VCA_W-1:0]    vca_r;
  logic                       skip_r;
  logic signed [SAMPLE_W-1:0] in_l_r;
  logic signed [SAMPLE_W-1:0] in_r_r;
  logic signed [CV_W-1:0]     gcv_r;
  logic signed [CV_W-1:0]     pcv_r;

  // Working registers
  logic        [GAIN_W-1:0]   g_r;
  logic        [TURN_BITS-1:0] phase_r;
  logic signed [TAB_W-1:0]    sin_r;
  logic signed [TAB_W-1:0]    cos_r;
  logic signed [GC_W-1:0]     gc_l_r;
  logic signed [GC_W-1:0]     gc_r_r;
  logic signed [PROD_W-1:0]   prod_l_r;
  logic signed [PROD_W-1:0]   prod_r_r;
  logic signed [OUT_W-1:0]    res_l_r;
  logic signed [OUT_W-1:0]    res_r_r;
  logic        [MIX_W-1:0]    mix_l_r;
  logic        [MIX_W-1:0]    mix_r_r;

  // Output register
  logic                       out_tvalid_r;
  logic [OUT_DATA_W-1:0]      out_tdata_r;
  logic [VCA_W-1:0]           out_tuser_r;

  logic signed [DIFF_W-1:0]   diff_g;
  logic signed [DIFF_W-1:0]   diff_p;
  logic signed [DIFF_W-1:0]   rnd_g;
  logic signed [DIFF_W-1:0]   rnd_p;
  logic signed [DIFF_W-1:0]   g_sum;
  logic        [GAIN_W-1:0]   g_nxt;
  logic        [TURN_BITS-1:0] phase_nxt;
  logic        [TBL_W-1:0]    sin_idx;
  logic        [TBL_W-1:0]    cos_idx;
  logic signed [MA_W-1:0]     mul_a;
  logic signed [MB_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic        [MIX_W-1:0]    mix_l_nxt;
  logic        [MIX_W-1:0]    mix_r_nxt;
  logic        [MIX_W-1:0]    mix_l_base;
  logic        [MIX_W-1:0]    mix_r_base;

  // Divide a product by 2^31, truncating toward zero
  function automatic logic signed [OUT_W-1:0] scale_q31(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    biased  = p + (p[PROD_W-1] ? PROD_W'((64'sd1 << SCALE_SHIFT) - 1) : '0);
    shifted = biased >>> SCALE_SHIFT;
    return shifted[OUT_W-1:0];
  endfunction

  assign status.vca_ok   = ({1'b0, in_tuser} < (VCA_W + 1)'(NUM_VCAS));
  assign status.out_busy = out_tvalid_r & ~out_tready;

  // Ramp step: (target - smooth) / RAMP_LENGTH, truncated toward zero
  always_comb begin
    diff_g = $signed({{(DIFF_W - TGT_W - 12){1'b0}}, tgt_gain_r[vca_r], 12'b0})
             - DIFF_W'(smooth_gain_r[vca_r]);
    diff_p = $signed({{(DIFF_W - TGT_W - 12){tgt_pan_r[vca_r][TGT_W-1]}},
                      tgt_pan_r[vca_r], 12'b0})
             - DIFF_W'(smooth_pan_r[vca_r]);
    rnd_g  = (diff_g + (diff_g[DIFF_W-1] ? DIFF_W'(RAMP_LENGTH - 1) : DIFF_W'(0)))
             >>> RAMP_SHIFT;
    rnd_p  = (diff_p + (diff_p[DIFF_W-1] ? DIFF_W'(RAMP_LENGTH - 1) : DIFF_W'(0)))
             >>> RAMP_SHIFT;
  end

  // Effective gain clamped to 0..3, and pan phase over a 2^27 turn
  always_comb begin
    g_sum = DIFF_W'(smooth_gain_r[vca_r]) + (DIFF_W'(gcv_r) <<< 12);
    if (g_sum[DIFF_W-1]) begin
      g_nxt = '0;
    end else if (g_sum > DIFF_W'(GAIN_MAX_Q24)) begin
      g_nxt = GAIN_W'(GAIN_MAX_Q24 >>> 8);
    end else begin
      g_nxt = g_sum[GAIN_W+7:8];
    end
    phase_nxt = smooth_pan_r[vca_r][TURN_BITS-1:0]
                + {pcv_r[TURN_BITS-13:0], 12'b0}
                + TURN_BITS'(64'sd1 << 24);
  end

  // Table indexes; cosine sits a quarter turn ahead
  assign sin_idx = phase_r[TURN_BITS-1 -: TBL_W];
  assign cos_idx = sin_idx + TBL_W'(SINE_TABLE_ENTRIES / 4);

  // Shared multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_GC_L: begin
        mul_a = MA_W'($signed({1'b0, g_r}));
        mul_b = MB_W'(cos_r);
      end
      MUL_GC_R: begin
        mul_a = MA_W'($signed({1'b0, g_r}));
        mul_b = MB_W'(sin_r);
      end
      MUL_OUT_L: begin
        mul_a = MA_W'(in_l_r);
        mul_b = MB_W'(gc_l_r);
      end
      MUL_OUT_R: begin
        mul_a = MA_W'(in_r_r);
        mul_b = MB_W'(gc_r_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Running mix restarts at VCA 0
  always_comb begin
    mix_l_base = (vca_r == '0) ? '0 : mix_l_r;
    mix_r_base = (vca_r == '0) ? '0 : mix_r_r;
    mix_l_nxt  = mix_l_base + MIX_W'(res_l_r);
    mix_r_nxt  = mix_r_base + MIX_W'(res_r_r);
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VCAS; i++) begin
        tgt_gain_r[i] <= TGT_W'(4096);
        tgt_pan_r[i]  <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        [REG_TARGET_GAIN_0:REG_TARGET_GAIN_3]: tgt_gain_r[cfg_index[VCA_W-1:0]] <= cfg_data;
        [REG_TARGET_PAN_0:REG_TARGET_PAN_3]:   tgt_pan_r[cfg_index[VCA_W-1:0]]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // VCA smoothing state: step at ramp start, then advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VCAS; i++) begin
        smooth_gain_r[i] <= '0;
        smooth_pan_r[i]  <= '0;
        gain_step_r[i]   <= '0;
        pan_step_r[i]    <= '0;
        ramp_pos_r[i]    <= '0;
      end
    end else begin
      if (cmd.step) begin
        if (ramp_pos_r[vca_r] == '0) begin
          gain_step_r[vca_r] <= rnd_g[SMOOTH_W-1:0];
          pan_step_r[vca_r]  <= rnd_p[SMOOTH_W-1:0];
        end
        if (ramp_pos_r[vca_r] == RAMP_W'(RAMP_LENGTH - 1)) begin
          ramp_pos_r[vca_r] <= '0;
        end else begin
          ramp_pos_r[vca_r] <= ramp_pos_r[vca_r] + 1'b1;
        end
      end
      if (cmd.smooth) begin
        smooth_gain_r[vca_r] <= smooth_gain_r[vca_r] + gain_step_r[vca_r];
        smooth_pan_r[vca_r]  <= smooth_pan_r[vca_r] + pan_step_r[vca_r];
      end
    end
  end

  // Item capture and the working pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vca_r  <= in_tuser;
      skip_r <= ~status.vca_ok;
      in_l_r <= in_tdata[SAMPLE_W-1:0];
      in_r_r <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      gcv_r  <= in_tdata[2*SAMPLE_W+CV_W-1:2*SAMPLE_W];
      pcv_r  <= in_tdata[2*SAMPLE_W+2*CV_W-1:2*SAMPLE_W+CV_W];
    end
    if (cmd.ctrl) begin
      g_r     <= g_nxt;
      phase_r <= phase_nxt;
    end
    if (cmd.tab_rd) begin
      sin_r <= SINE_TABLE[sin_idx];
      cos_r <= SINE_TABLE[cos_idx];
    end
    case (cmd.mul_sel)
      MUL_GC_L:  gc_l_r   <= mul_p[GC_W-1:0];
      MUL_GC_R:  gc_r_r   <= mul_p[GC_W-1:0];
      MUL_OUT_L: prod_l_r <= mul_p;
      MUL_OUT_R: prod_r_r <= mul_p;
      default: ;
    endcase
    if (cmd.scale) begin
      res_l_r <= scale_q31(prod_l_r);
      res_r_r <= scale_q31(prod_r_r);
    end
  end

  // Mix sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_l_r <= '0;
      mix_r_r <= '0;
    end else if (cmd.load && !skip_r) begin
      mix_l_r <= mix_l_nxt;
      mix_r_r <= mix_r_nxt;
    end
  end

  // Output register: load a transaction, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tuser_r <= vca_r;
      if (skip_r) begin
        out_tdata_r <= OUT_DATA_W'({mix_r_r, mix_l_r, {(2 * OUT_W){1'b0}}});
      end else begin
        out_tdata_r <= OUT_DATA_W'({mix_r_nxt, mix_l_nxt, res_r_r, res_l_r});
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: src/stereo_vca_pan_mixer_core.sv
// Top level of the stereo VCA pan mixer: controller, datapath and configuration port.
//
// Usage:
//   Input channel in_*: one stereo sample and two control voltages for one VCA per
//   transaction; in_tuser selects the VCA, and VCA 0 starts a new mix frame.
//   Result channel out_*: the VCA's scaled left/right samples and the running mix.
//   Configuration channel cfg_*: gain targets (indexes 0..3) and pan targets (4..7),
//   always ready; write only while no item is in flight.
//   One item is worked at a time: a new one is taken once the last has loaded
//   the output register, which for a valid VCA follows the per-VCA state update
//   (step, smooth, control), the table read, the four passes through the single
//   shared multiplier and the scale.
//   The output register parts the two sides: while a result waits, the next item
//   is accepted and runs up to its mix stage, where it holds until the receiver
//   takes the waiting result.
//   Reset (synchronous, active low) clears the smoothing state, the ramp counters,
//   the mix sums and the output valid, and sets gain targets to 1.0, pan to center.
`timescale 1ns / 1ps

module stereo_vca_pan_mixer_core
  import svpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: in_left[23:0], in_right[47:24], gain_cv[63:48], pan_cv[79:64]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: vca_index[1:0]
  input  logic [VCA_W-1:0]      in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: out_left[25:0], out_right[51:26], mix_left[79:52], mix_right[107:80],
  // zero pad[111:108]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: vca_number[1:0]
  output logic [VCA_W-1:0]      out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TGT_W-1:0]      cfg_data
);

  svpm_cmd_t    cmd;
  svpm_status_t status;

  assign cfg_ready = 1'b1;

  svpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  svpm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: src/svpm_checker.sv
// Port-level checks of the stereo VCA pan mixer, bound to the top level.
`timescale 1ns / 1ps

module svpm_checker
  import svpm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [VCA_W-1:0]      out_tuser
);

  // A stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // One item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // VCA 0 restarts the mix: its mix equals its own output
  a_mix_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == '0) |->
      (out_tdata[79:52] == {{2{out_tdata[25]}}, out_tdata[25:0]}) &&
      (out_tdata[107:80] == {{2{out_tdata[51]}}, out_tdata[51:26]}))
    else $error("mix did not restart at VCA 0");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind stereo_vca_pan_mixer_core svpm_checker u_svpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/tb_stereo_vca_pan_mixer_core.sv
// Self-checking testbench for the stereo VCA pan mixer core, with its own gain/pan/mix model.
`timescale 1ns / 1ps

module tb_stereo_vca_pan_mixer_core;
  import svpm_pkg::*;

  localparam int     RUN_LIMIT     = 500000;
  localparam int     SETTINGS_RUNS = 5;
  localparam int     ITEMS_PER_RUN = 346;
  localparam longint Q30_ONE       = 64'sd1 << 30;
  localparam longint QUARTER_POLY [5] = '{
    64'sd1686629713, -64'sd693598669, 64'sd85569306, -64'sd5026984, 64'sd172270
  };

  typedef struct packed {
    logic [VCA_W-1:0]    vca;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [CV_W-1:0]     gain_cv;
    logic [CV_W-1:0]     pan_cv;
  } stereo_item_t;

  typedef struct packed {
    logic [VCA_W-1:0] vca;
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] right;
    logic [MIX_W-1:0] mix_left;
    logic [MIX_W-1:0] mix_right;
  } mix_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [VCA_W-1:0]      in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [VCA_W-1:0]      out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TGT_W-1:0]      cfg_data = '0;

  stereo_vca_pan_mixer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state: targets, smoothed controls (Q8.24), ramp counters, mix sums
  int          sine_tab [SINE_TABLE_ENTRIES];
  int          gain_target [NUM_VCAS];
  int          pan_target [NUM_VCAS];
  int          smooth_gain_q24 [NUM_VCAS];
  int          smooth_pan_q24 [NUM_VCAS];
  int          gain_inc [NUM_VCAS];
  int          pan_inc [NUM_VCAS];
  int          ramp_count [NUM_VCAS];
  logic [MIX_W-1:0] mix_acc_left;
  logic [MIX_W-1:0] mix_acc_right;

  stereo_item_t stereo_items [$];
  mix_result_t  expected_mixes [$];

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          in_gap_left = 0;
  int          in_sent = 0;
  int          out_stall_left = 0;
  int          out_taken = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  mix_result_t mix_want;
  mix_result_t mix_got;

  // Ramp, clamp, pan lookup and scale for one VCA sample
  function automatic mix_result_t predict_vca_mix(input logic [VCA_W-1:0] vca,
                                                  input logic signed [SAMPLE_W-1:0] in_l,
                                                  input logic signed [SAMPLE_W-1:0] in_r,
                                                  input logic signed [CV_W-1:0] gcv,
                                                  input logic signed [CV_W-1:0] pcv);
    mix_result_t res;
    longint      diff;
    longint      gain_q16;
    longint      pan_sum;
    longint      left_out;
    longint      right_out;
    logic [TURN_BITS-1:0] sin_phase;
    logic [TURN_BITS-1:0] cos_phase;
    int          sin_idx;
    int          cos_idx;
    res.vca = vca;
    if (int'(vca) >= NUM_VCAS) begin
      res.left      = '0;
      res.right     = '0;
      res.mix_left  = mix_acc_left;
      res.mix_right = mix_acc_right;
      return res;
    end
    // Start of a ramp block: recompute the per-item steps
    if (ramp_count[vca] == 0) begin
      diff = longint'(gain_target[vca]) * 4096 - smooth_gain_q24[vca];
      gain_inc[vca] = int'(diff / RAMP_LENGTH);
      diff = longint'(pan_target[vca]) * 4096 - smooth_pan_q24[vca];
      pan_inc[vca] = int'(diff / RAMP_LENGTH);
    end
    smooth_gain_q24[vca] = smooth_gain_q24[vca] + gain_inc[vca];
    smooth_pan_q24[vca]  = smooth_pan_q24[vca] + pan_inc[vca];
    ramp_count[vca] = (ramp_count[vca] + 1 >= RAMP_LENGTH) ? 0 : ramp_count[vca] + 1;

    // Clamp gain to 0..3, drop to Q16
    gain_q16 = longint'(smooth_gain_q24[vca]) + longint'(gcv) * 4096;
    if (gain_q16 < 0) gain_q16 = 0;
    if (gain_q16 > (64'sd3 << 24)) gain_q16 = 64'sd3 << 24;
    gain_q16 = gain_q16 / 256;

    // Pan wraps around the full turn; cos is a quarter turn ahead
    pan_sum   = longint'(smooth_pan_q24[vca]) + longint'(pcv) * 4096 + (64'sd1 << 24);
    sin_phase = pan_sum[TURN_BITS-1:0];
    cos_phase = sin_phase + (27'd1 << (TURN_BITS - 2));
    sin_idx   = int'((longint'(sin_phase) * SINE_TABLE_ENTRIES) >>> TURN_BITS);
    cos_idx   = int'((longint'(cos_phase) * SINE_TABLE_ENTRIES) >>> TURN_BITS);

    left_out  = (longint'(in_l) * gain_q16 * sine_tab[cos_idx]) / (64'sd1 << 31);
    right_out = (longint'(in_r) * gain_q16 * sine_tab[sin_idx]) / (64'sd1 << 31);

    // VCA 0 restarts the mix frame
    if (vca == '0) begin
      mix_acc_left  = left_out[MIX_W-1:0];
      mix_acc_right = right_out[MIX_W-1:0];
    end else begin
      mix_acc_left  = mix_acc_left + left_out[MIX_W-1:0];
      mix_acc_right = mix_acc_right + right_out[MIX_W-1:0];
    end
    res.left      = left_out[OUT_W-1:0];
    res.right     = right_out[OUT_W-1:0];
    res.mix_left  = mix_acc_left;
    res.mix_right = mix_acc_right;
    return res;
  endfunction

  // Calm stretches of 24 transactions out of every 128, random waits elsewhere
  function automatic int draw_wait(input int count);
    if ((count % 128) < 24) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return '0;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Mostly moderate control voltages so the gain clamp is not always hit
  function automatic logic [CV_W-1:0] draw_cv();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return CV_W'($urandom());
      default: return CV_W'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic queue_item(input int vca, input int left, input int right,
                            input int gain_cv, input int pan_cv);
    stereo_item_t it;
    it.vca     = VCA_W'(vca);
    it.left    = SAMPLE_W'(left);
    it.right   = SAMPLE_W'(right);
    it.gain_cv = CV_W'(gain_cv);
    it.pan_cv  = CV_W'(pan_cv);
    stereo_items = {stereo_items, it};
  endtask

  task automatic queue_random_item(input int vca);
    stereo_item_t it;
    it.vca     = VCA_W'(vca);
    it.left    = draw_sample();
    it.right   = draw_sample();
    it.gain_cv = draw_cv();
    it.pan_cv  = draw_cv();
    stereo_items = {stereo_items, it};
  endtask

  task automatic write_target(input logic [CFG_IDX_W-1:0] idx, input logic [TGT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  // Hold until every queued item is sent and every result has come back
  task automatic wait_drained();
    while (stereo_items.size() != 0 || in_tvalid || expected_mixes.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [MIX_W-1:0] want,
                             input logic [MIX_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Input driver: present the next item at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_tvalid <= 1'b0;
      end else if (stereo_items.size() != 0) begin
        in_tdata  <= {stereo_items[0].pan_cv, stereo_items[0].gain_cv,
                      stereo_items[0].right, stereo_items[0].left};
        in_tuser  <= stereo_items[0].vca;
        in_tvalid <= 1'b1;
        void'(stereo_items.pop_front());
        in_sent++;
        in_gap_left = draw_wait(in_sent);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: drop ready for a random stall after each transaction
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_fire) begin
      out_taken++;
      out_stall_left = draw_wait(out_taken);
      out_tready <= (out_stall_left == 0);
    end else if (out_stall_left > 0) begin
      out_stall_left--;
      out_tready <= (out_stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: mirror register writes, predict accepted items, check results
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
    end else begin
      in_fire  <= in_tvalid && in_tready;
      out_fire <= out_tvalid && out_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_TARGET_GAIN_3)
          gain_target[cfg_index - REG_TARGET_GAIN_0] = int'(cfg_data);
        else if (cfg_index <= REG_TARGET_PAN_3)
          pan_target[cfg_index - REG_TARGET_PAN_0] = int'($signed(cfg_data));
      end
      if (in_tvalid && in_tready)
        expected_mixes = {expected_mixes,
                          predict_vca_mix(in_tuser, in_tdata[23:0], in_tdata[47:24],
                                          in_tdata[63:48], in_tdata[79:64])};
      if (out_tvalid && out_tready) begin
        mix_got.vca       = out_tuser;
        mix_got.left      = out_tdata[25:0];
        mix_got.right     = out_tdata[51:26];
        mix_got.mix_left  = out_tdata[79:52];
        mix_got.mix_right = out_tdata[107:80];
        if (expected_mixes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: %h", mix_got);
        end else begin
          mix_want = expected_mixes.pop_front();
          check_field("vca_number", MIX_W'(mix_want.vca), MIX_W'(mix_got.vca));
          check_field("out_left", MIX_W'(mix_want.left), MIX_W'(mix_got.left));
          check_field("out_right", MIX_W'(mix_want.right), MIX_W'(mix_got.right));
          check_field("mix_left", mix_want.mix_left, mix_got.mix_left);
          check_field("mix_right", mix_want.mix_right, mix_got.mix_right);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    longint quad;
    longint u;
    longint u2;
    longint acc;
    longint s;
    longint mag;
    int     k;
    int     i;
    int     v;
    int     setting;
    int     count;
    int     frame_len;
    logic [TGT_W-1:0] gval;
    logic [TGT_W-1:0] pval;

    // Quarter-wave polynomial sine table, folded over four quadrants
    for (k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      quad = (64'sd4 * k) / SINE_TABLE_ENTRIES;
      u = ((64'sd4 * k - quad * SINE_TABLE_ENTRIES) * Q30_ONE) / SINE_TABLE_ENTRIES;
      if (quad % 2 == 1) u = Q30_ONE - u;
      u2 = (u * u) / Q30_ONE;
      acc = QUARTER_POLY[4];
      for (i = 3; i >= 0; i--) acc = QUARTER_POLY[i] + (acc * u2) / Q30_ONE;
      s = (acc * u) / Q30_ONE;
      if (s < 0) s = 0;
      mag = (s + 64'sd16384) / 64'sd32768;
      if (mag > 32767) mag = 32767;
      sine_tab[k] = (quad >= 2) ? -int'(mag) : int'(mag);
    end
    for (v = 0; v < NUM_VCAS; v++) begin
      gain_target[v]     = 4096;
      pan_target[v]      = 0;
      smooth_gain_q24[v] = 0;
      smooth_pan_q24[v]  = 0;
      gain_inc[v]        = 0;
      pan_inc[v]         = 0;
      ramp_count[v]      = 0;
    end
    mix_acc_left  = '0;
    mix_acc_right = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: sample and control extremes, pan past +-1, full clamp both ways
    queue_item(0, 0, 0, 0, 0);
    queue_item(0, 8388607, -8388608, 32767, 0);
    queue_item(1, -8388608, 8388607, 32767, 0);
    queue_item(2, 8388607, 8388607, 32767, 32767);
    queue_item(3, -8388608, -8388608, -32768, -32768);
    queue_item(0, -1, 1, 0, 4096);
    queue_item(1, 12345, -12345, 0, -4096);
    queue_item(2, 8388607, -8388608, 8192, 8192);
    queue_item(3, -8388608, 8388607, 8192, -8192);
    // Long run without VCA 0 at full gain wraps the mix sums
    for (i = 0; i < 12; i++) queue_item(1 + (i % 3), 8388607, 8388607, 32767, 0);
    queue_item(0, 100, -100, 0, 0);
    wait_drained();

    for (setting = 1; setting <= SETTINGS_RUNS; setting++) begin
      repeat (12) @(posedge clk);
      for (v = 0; v < NUM_VCAS; v++) begin
        case (setting)
          1: begin
            gval = TGT_W'(12288);
            pval = v[0] ? TGT_W'(4096) : TGT_W'(-4096);
          end
          2: begin
            // Gain target above 3 and the pan field's own extremes
            gval = v[0] ? TGT_W'(16383) : '0;
            pval = v[0] ? TGT_W'(-8192) : TGT_W'(8191);
          end
          default: begin
            gval = TGT_W'($urandom_range(0, 12288));
            pval = TGT_W'($urandom_range(0, 8192) - 4096);
            if ($urandom_range(0, 3) == 0) begin
              gval = TGT_W'($urandom());
              pval = TGT_W'($urandom());
            end
          end
        endcase
        write_target(CFG_IDX_W'(REG_TARGET_GAIN_0 + v), gval);
        write_target(CFG_IDX_W'(REG_TARGET_PAN_0 + v), pval);
      end
      @(negedge clk);
      cfg_valid <= 1'b0;

      // Mostly whole frames 0..N-1, some cut short, some lone VCAs
      count = 0;
      while (count < ITEMS_PER_RUN) begin
        if ($urandom_range(0, 9) < 8) begin
          frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, NUM_VCAS - 1) : NUM_VCAS;
          for (v = 0; v < frame_len; v++) queue_random_item(v);
          count += frame_len;
        end else begin
          queue_random_item($urandom_range(0, NUM_VCAS - 1));
          count++;
        end
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
